// ===== hdl/buffer_frame_table_replacer_macros.svh =====
// assertion helpers for the frame table
`ifndef BUFFER_FRAME_TABLE_REPLACER_MACROS_SVH
`define BUFFER_FRAME_TABLE_REPLACER_MACROS_SVH
// implication checked on every clock edge outside reset
`define BFTR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define BFTR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/bftr_pkg.sv =====
`default_nettype none
package bftr_pkg;
  localparam logic [1:0] OP_PIN   = 2'd0;
  localparam logic [1:0] OP_UNPIN = 2'd1;
  localparam logic [1:0] OP_DIRTY = 2'd2;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_LOADED  = 3'd1;
  localparam logic [2:0] ST_EVICTED = 3'd2;
  localparam logic [2:0] ST_PINNED  = 3'd3;
  localparam logic [2:0] ST_ABSENT  = 3'd4;

  localparam logic [7:0] PIN_MAX = 8'hFF;

  localparam logic [1:0] REG_POLICY = 2'd0;
  localparam logic [1:0] REG_FRAMES = 2'd1;
endpackage
`default_nettype wire

// ===== hdl/bftr_scan.sv =====
`default_nettype none
// walks the frame memory one entry per cycle while step is high: page match and oldest unpinned frame
module bftr_scan #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 20,
  parameter int FW = $clog2(NUM_FRAMES)
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 clr,
  input  wire logic                 step,
  input  wire logic [FW-1:0]        idx,
  input  wire logic [PAGE_BITS-1:0] page,
  input  wire logic [PAGE_BITS-1:0] ent_page,
  input  wire logic [7:0]           ent_pins,
  input  wire logic [FW-1:0]        ent_rank,
  output logic                      hit_r,
  output logic [FW-1:0]             hit_idx_r,
  output logic                      vic_r,
  output logic [FW-1:0]             vic_idx_r
);
  logic [FW-1:0] vic_rank_r;
  logic hit_nxt, vic_nxt;
  logic [FW-1:0] hit_idx_nxt, vic_idx_nxt, vic_rank_nxt;

  always_comb begin
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    vic_nxt = vic_r;
    vic_idx_nxt = vic_idx_r;
    vic_rank_nxt = vic_rank_r;
    if (clr) begin
      hit_nxt = 1'b0;
      vic_nxt = 1'b0;
    end else if (step) begin
      // first match wins
      if (!hit_r && ent_page == page) begin
        hit_nxt = 1'b1;
        hit_idx_nxt = idx;
      end
      if (ent_pins == 8'd0 && (!vic_r || ent_rank > vic_rank_r)) begin
        vic_nxt = 1'b1;
        vic_idx_nxt = idx;
        vic_rank_nxt = ent_rank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
      vic_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
      vic_r <= vic_nxt;
    end
    hit_idx_r <= hit_idx_nxt;
    vic_idx_r <= vic_idx_nxt;
    vic_rank_r <= vic_rank_nxt;
  end
endmodule
`default_nettype wire

// ===== hdl/buffer_frame_table_replacer.sv =====
`default_nettype none
// Frame table of a page buffer pool. Pulse start while busy is low with op and
// page_number; one result follows on out_* for a single cycle, marked by
// out_valid, and cannot be held off. With U the number of used frames, a request
// that changes a frame keeps busy high through a scan of the U used frames and a
// pass over all entries; one that leaves the table alone (not resident, all
// pinned, unused op) ends after the scan. One pass over the U used frames (one
// read port) finds the match and the victim, a second read-modify-write pass
// over all NUM_FRAMES entries updates ranks and the chosen frame. After reset a
// clearing pass over all NUM_FRAMES entries initializes the frame memory;
// configuration writes are taken during it.
`include "buffer_frame_table_replacer_macros.svh"
module buffer_frame_table_replacer #(
  parameter int NUM_FRAMES = 16,
  parameter int PAGE_BITS  = 20
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           in_op,
  input  wire logic [19:0]          in_page_number,
  output logic                      out_valid,
  output logic [2:0]                out_status,
  output logic [3:0]                out_frame,
  output logic                      out_fetch_needed,
  output logic                      out_write_back_valid,
  output logic [19:0]               out_write_back_page,
  output logic [7:0]                out_pin_count,
  output logic [31:0]               out_read_count,
  output logic [31:0]               out_write_count,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int EW = PAGE_BITS + 8 + 1 + FW;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DEC   = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  // entry: page, pins, dirty, rank
  logic [EW-1:0] mem [NUM_FRAMES];
  logic [EW-1:0] rd_r;
  logic [FW-1:0] raddr;
  logic          we;
  logic [FW-1:0] waddr;
  logic [EW-1:0] wdata;

  logic [2:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic rd_vld_r;
  logic [FW-1:0] rd_idx_r;
  logic [1:0] op_r;
  logic [PAGE_BITS-1:0] page_r;
  logic policy_r;
  logic [4:0] frames_r;
  logic [CW-1:0] used_r, used_nxt;
  logic [31:0] reads_r, reads_nxt, writes_r, writes_nxt;

  // decision
  logic [FW-1:0] tgt_r, tgt_nxt;
  logic [FW-1:0] trank_r, trank_nxt;
  logic reorder_r, reorder_nxt;
  logic [2:0] st_r, st_nxt;

  logic [PAGE_BITS-1:0] e_page;
  logic [7:0] e_pins;
  logic e_dirty;
  logic [FW-1:0] e_rank;
  assign {e_page, e_pins, e_dirty, e_rank} = rd_r;

  logic hit, vic;
  logic [FW-1:0] hit_idx, vic_idx;
  logic scan_clr, scan_step;

  logic [CW-1:0] limit;
  logic [4:0] lim5;
  always_comb begin
    lim5 = (frames_r == 5'd0) ? 5'd1 : frames_r;
    if ({1'b0, lim5} > 6'(NUM_FRAMES)) limit = CW'(NUM_FRAMES);
    else limit = CW'(lim5);
  end

  assign scan_clr = (state_r == S_IDLE) && start;
  assign scan_step = (state_r == S_SCAN) && rd_vld_r;

  bftr_scan #(.NUM_FRAMES(NUM_FRAMES), .PAGE_BITS(PAGE_BITS), .FW(FW)) u_scan (
    .clk, .rst_n, .clr(scan_clr), .step(scan_step), .idx(rd_idx_r), .page(page_r),
    .ent_page(e_page), .ent_pins(e_pins), .ent_rank(e_rank),
    .hit_r(hit), .hit_idx_r(hit_idx), .vic_r(vic), .vic_idx_r(vic_idx)
  );

  logic pin_op;
  assign pin_op = (op_r == bftr_pkg::OP_PIN);

  // output regs
  logic ov_r;
  logic [2:0] o_st_r;
  logic [FW-1:0] o_fr_r;
  logic o_fetch_r, o_wbv_r;
  logic [PAGE_BITS-1:0] o_wbp_r;
  logic [7:0] o_pins_r;
  logic set_out;
  logic o_fetch_nxt, o_wbv_nxt;
  logic [PAGE_BITS-1:0] o_wbp_nxt;
  logic [7:0] o_pins_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    raddr = cnt_r[FW-1:0];
    we = 1'b0;
    waddr = rd_idx_r;
    wdata = rd_r;
    used_nxt = used_r;
    reads_nxt = reads_r;
    writes_nxt = writes_r;
    tgt_nxt = tgt_r;
    trank_nxt = trank_r;
    reorder_nxt = reorder_r;
    st_nxt = st_r;
    set_out = 1'b0;
    o_fetch_nxt = 1'b0;
    o_wbv_nxt = 1'b0;
    o_wbp_nxt = '0;
    o_pins_nxt = 8'd0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1;
        waddr = cnt_r[FW-1:0];
        wdata = {{PAGE_BITS{1'b0}}, 8'd0, 1'b0, cnt_r[FW-1:0]};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(NUM_FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // issue reads for frames below used_r, then decide
        if (cnt_r < used_r) begin
          cnt_nxt = cnt_r + 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cnt_nxt = '0;
        reorder_nxt = 1'b0;
        state_nxt = S_UPD;
        if (hit && (op_r inside {bftr_pkg::OP_PIN, bftr_pkg::OP_UNPIN, bftr_pkg::OP_DIRTY})) begin
          tgt_nxt = hit_idx;
          st_nxt = bftr_pkg::ST_HIT;
          reorder_nxt = pin_op && policy_r;
        end else if (pin_op && used_r < limit) begin
          tgt_nxt = used_r[FW-1:0];
          st_nxt = bftr_pkg::ST_LOADED;
          reorder_nxt = 1'b1;
          used_nxt = used_r + 1'b1;
          reads_nxt = reads_r + 32'd1;
        end else if (pin_op && vic) begin
          tgt_nxt = vic_idx;
          st_nxt = bftr_pkg::ST_EVICTED;
          reorder_nxt = 1'b1;
          reads_nxt = reads_r + 32'd1;
        end else begin
          st_nxt = pin_op ? bftr_pkg::ST_PINNED : bftr_pkg::ST_ABSENT;
          state_nxt = S_OUT;
        end
        raddr = tgt_nxt;
      end
      S_UPD: begin
        // target read first to learn its rank, then all frames
        if (cnt_r <= CW'(NUM_FRAMES)) begin
          cnt_nxt = cnt_r + 1'b1;
          raddr = (cnt_r == '0) ? tgt_r : cnt_r[FW-1:0] - 1'b1;
        end
        if (rd_vld_r) begin
          if (cnt_r == CW'(1)) begin
            trank_nxt = e_rank;
            // target update
            we = 1'b1;
            waddr = tgt_r;
            set_out = 1'b1;
            if (st_r == bftr_pkg::ST_HIT) begin
              case (op_r)
                bftr_pkg::OP_PIN: begin
                  o_pins_nxt = (e_pins == bftr_pkg::PIN_MAX) ? e_pins : e_pins + 8'd1;
                  wdata = {e_page, o_pins_nxt, e_dirty, reorder_r ? {FW{1'b0}} : e_rank};
                end
                bftr_pkg::OP_UNPIN: begin
                  o_pins_nxt = (e_pins == 8'd0) ? e_pins : e_pins - 8'd1;
                  wdata = {e_page, o_pins_nxt, e_dirty, e_rank};
                end
                default: begin
                  o_pins_nxt = e_pins;
                  wdata = {e_page, e_pins, 1'b1, e_rank};
                end
              endcase
            end else begin
              o_fetch_nxt = 1'b1;
              o_pins_nxt = 8'd1;
              o_wbv_nxt = (st_r == bftr_pkg::ST_EVICTED) && e_dirty;
              o_wbp_nxt = o_wbv_nxt ? e_page : '0;
              if (o_wbv_nxt) writes_nxt = writes_r + 32'd1;
              wdata = {page_r, 8'd1, 1'b0, {FW{1'b0}}};
            end
          end else if (rd_idx_r != tgt_r && reorder_r && e_rank < trank_r) begin
            we = 1'b1;
            wdata = {e_page, e_pins, e_dirty, e_rank + 1'b1};
          end
          if (cnt_r == CW'(NUM_FRAMES + 1)) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!ov_r && !(st_r inside {bftr_pkg::ST_HIT, bftr_pkg::ST_LOADED,
                                    bftr_pkg::ST_EVICTED})) begin
          set_out = 1'b1;
        end
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // the read issued in a cycle returns next cycle; track which entry it is
  logic issue;
  assign issue = ((state_r == S_SCAN) && cnt_r < used_r)
              || ((state_r == S_UPD) && cnt_r <= CW'(NUM_FRAMES));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r <= '0;
      rd_vld_r <= 1'b0;
      used_r <= '0;
      reads_r <= '0;
      writes_r <= '0;
      policy_r <= 1'b1;
      frames_r <= 5'd16;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      rd_vld_r <= issue;
      used_r <= used_nxt;
      reads_r <= reads_nxt;
      writes_r <= writes_nxt;
      ov_r <= set_out;
      if (psel && penable && pwrite) begin
        if (paddr[2] == bftr_pkg::REG_POLICY[0]) policy_r <= pwdata[0];
        else frames_r <= pwdata[4:0];
      end
    end
    rd_idx_r <= raddr;
    tgt_r <= tgt_nxt;
    trank_r <= trank_nxt;
    reorder_r <= reorder_nxt;
    st_r <= st_nxt;
    if (state_r == S_IDLE && start) begin
      op_r <= in_op;
      page_r <= PAGE_BITS'(in_page_number);
    end
    if (set_out) begin
      o_st_r <= st_r;
      o_fr_r <= (st_r == bftr_pkg::ST_PINNED || st_r == bftr_pkg::ST_ABSENT) ? '0 : tgt_r;
      o_fetch_r <= o_fetch_nxt;
      o_wbv_r <= o_wbv_nxt;
      o_wbp_r <= o_wbp_nxt;
      o_pins_r <= o_pins_nxt;
    end
  end

  // the result leaves in the cycle after set_out, counters already final
  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_status = o_st_r;
  assign out_frame = 4'(o_fr_r);
  assign out_fetch_needed = o_fetch_r;
  assign out_write_back_valid = o_wbv_r;
  assign out_write_back_page = 20'(o_wbp_r);
  assign out_pin_count = o_pins_r;
  assign out_read_count = reads_r;
  assign out_write_count = writes_r;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == bftr_pkg::REG_FRAMES[0]) ? {27'd0, frames_r}
                                                       : {31'd0, policy_r};

  `BFTR_ASSERT_IMP(a_used_bound, 1'b1, used_r <= CW'(NUM_FRAMES), "used frames overflow")
  `BFTR_ASSERT_NXT(a_busy_after_start, state_r == S_IDLE && start, busy, "request not taken")
  `BFTR_ASSERT_IMP(a_fetch_load, out_valid && out_fetch_needed,
    out_status == bftr_pkg::ST_LOADED || out_status == bftr_pkg::ST_EVICTED, "bad fetch")
  `BFTR_ASSERT_IMP(a_wb_page, out_valid && !out_write_back_valid,
    out_write_back_page == 20'd0, "stray write-back page")
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  localparam int NFR = 16;
  localparam longint LIMIT = 2000000;
  // op code with no meaning
  localparam logic [1:0] OP_BAD = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  frame;
    logic        fetch;
    logic        wbv;
    logic [19:0] wbp;
    logic [7:0]  pins;
    logic [31:0] reads;
    logic [31:0] writes;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] in_op = '0;
  logic [19:0] in_page_number = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic [3:0] out_frame;
  logic out_fetch_needed, out_write_back_valid;
  logic [19:0] out_write_back_page;
  logic [7:0] out_pin_count;
  logic [31:0] out_read_count, out_write_count;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // predictor state
  logic        pol;
  logic [4:0]  fin;
  logic [19:0] pg_of [NFR];
  logic [7:0]  pin_of [NFR];
  logic        dirty_of [NFR];
  logic [3:0]  rank_of [NFR];
  int          used;
  logic [31:0] nreads, nwrites;

  pool_result_t pending_results[$];
  int  errors = 0;
  longint cycles = 0;
  logic [19:0] hot_pages[$];

  buffer_frame_table_replacer i_dut (.*);

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout at %0t", $time);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic void report(string fld, longint unsigned e, longint unsigned a);
    errors++;
    $display("%0t: %s expected %0h actual %0h", $time, fld, e, a);
  endfunction

  // result checker
  always @(posedge clk) begin
    pool_result_t got, want;
    if (rst_n && out_valid) begin
      got = '{out_status, out_frame, out_fetch_needed, out_write_back_valid,
              out_write_back_page, out_pin_count, out_read_count, out_write_count};
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) report("status", want.status, got.status);
        if (got.frame !== want.frame) report("frame", want.frame, got.frame);
        if (got.fetch !== want.fetch) report("fetch_needed", want.fetch, got.fetch);
        if (got.wbv !== want.wbv) report("write_back_valid", want.wbv, got.wbv);
        if (got.wbp !== want.wbp) report("write_back_page", want.wbp, got.wbp);
        if (got.pins !== want.pins) report("pin_count", want.pins, got.pins);
        if (got.reads !== want.reads) report("read_count", want.reads, got.reads);
        if (got.writes !== want.writes) report("write_count", want.writes, got.writes);
      end
    end
  end

  function automatic void pool_clear();
    pol = 1'b1;
    fin = 5'd16;
    for (int i = 0; i < NFR; i++) begin
      pg_of[i] = '0; pin_of[i] = '0; dirty_of[i] = 1'b0; rank_of[i] = 4'(i);
    end
    used = 0; nreads = '0; nwrites = '0;
  endfunction

  function automatic void promote(int f);
    logic [3:0] r;
    r = rank_of[f];
    for (int i = 0; i < NFR; i++)
      if (rank_of[i] < r) rank_of[i]++;
    rank_of[f] = '0;
  endfunction

  function automatic pool_result_t predict_request(logic [1:0] op, logic [19:0] pg);
    pool_result_t r;
    int hit, lim, victim;
    r = '0;
    r.status = bftr_pkg::ST_ABSENT;
    hit = -1;
    for (int i = 0; i < used; i++)
      if (hit < 0 && pg_of[i] == pg) hit = i;
    lim = (fin < 1) ? 1 : (fin > NFR) ? NFR : int'(fin);
    if (op == bftr_pkg::OP_PIN) begin
      if (hit >= 0) begin
        if (pin_of[hit] != bftr_pkg::PIN_MAX) pin_of[hit]++;
        if (pol) promote(hit);
        r.status = bftr_pkg::ST_HIT; r.frame = 4'(hit); r.pins = pin_of[hit];
      end else if (used < lim) begin
        victim = used;
        used++;
        promote(victim);
        pg_of[victim] = pg; pin_of[victim] = 8'd1; dirty_of[victim] = 1'b0;
        nreads++;
        r.status = bftr_pkg::ST_LOADED; r.frame = 4'(victim); r.fetch = 1'b1;
        r.pins = 8'd1;
      end else begin
        victim = -1;
        for (int i = 0; i < used; i++)
          if (pin_of[i] == 0 && (victim < 0 || rank_of[i] > rank_of[victim])) victim = i;
        if (victim < 0) r.status = bftr_pkg::ST_PINNED;
        else begin
          promote(victim);
          if (dirty_of[victim]) begin
            r.wbv = 1'b1; r.wbp = pg_of[victim]; nwrites++;
          end
          pg_of[victim] = pg; pin_of[victim] = 8'd1; dirty_of[victim] = 1'b0;
          nreads++;
          r.status = bftr_pkg::ST_EVICTED; r.frame = 4'(victim); r.fetch = 1'b1;
          r.pins = 8'd1;
        end
      end
    end else if ((op == bftr_pkg::OP_UNPIN || op == bftr_pkg::OP_DIRTY) && hit >= 0) begin
      if (op == bftr_pkg::OP_UNPIN) begin
        if (pin_of[hit] != 0) pin_of[hit]--;
      end else dirty_of[hit] = 1'b1;
      r.status = bftr_pkg::ST_HIT; r.frame = 4'(hit); r.pins = pin_of[hit];
    end
    r.reads = nreads;
    r.writes = nwrites;
    return r;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_request(logic [1:0] op, logic [19:0] pg);
    in_op <= op;
    in_page_number <= pg;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    pending_results.push_back(predict_request(op, pg));
    start <= 1'b0;
    @(posedge clk);
    idle_gap();
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 1'b0} << 1; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == bftr_pkg::REG_POLICY) pol = val[0];
    else fin = val[4:0];
    @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(bftr_pkg::OP_UNPIN, 20'hFFFFF);
    send_request(bftr_pkg::OP_DIRTY, 20'h0);
    send_request(bftr_pkg::OP_PIN, 20'h0);
    send_request(bftr_pkg::OP_PIN, 20'hFFFFF);
    send_request(bftr_pkg::OP_PIN, 20'h0);
    send_request(bftr_pkg::OP_UNPIN, 20'h0);
    send_request(bftr_pkg::OP_UNPIN, 20'h0);
    send_request(bftr_pkg::OP_UNPIN, 20'h0);
    send_request(bftr_pkg::OP_DIRTY, 20'h0);
    send_request(OP_BAD, 20'h0);
    send_request(OP_BAD, 20'h12345);
    // pin saturation on one page
    repeat (258) send_request(bftr_pkg::OP_PIN, 20'hAAAAA);
    send_request(bftr_pkg::OP_UNPIN, 20'hAAAAA);
    wait_drained();
  endtask

  task automatic test_small_pool();
    write_reg(bftr_pkg::REG_FRAMES, 32'd0);
    send_request(bftr_pkg::OP_PIN, 20'h55555);
    send_request(bftr_pkg::OP_PIN, 20'h11111);
    send_request(bftr_pkg::OP_UNPIN, 20'hFFFFF);
    send_request(bftr_pkg::OP_DIRTY, 20'hFFFFF);
    send_request(bftr_pkg::OP_PIN, 20'h22222);
    send_request(bftr_pkg::OP_UNPIN, 20'h0);
    send_request(bftr_pkg::OP_PIN, 20'h33333);
    wait_drained();
  endtask

  task automatic random_phase(int n, int pages);
    logic [1:0] op;
    logic [19:0] pg;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 19) == 0) pg = 20'($urandom);
      else pg = hot_pages[$urandom_range(0, pages - 1)];
      case ($urandom_range(0, 19))
        0: op = OP_BAD;
        1, 2, 3, 4, 5, 6, 7: op = bftr_pkg::OP_PIN;
        8, 9, 10, 11, 12, 13, 14: op = bftr_pkg::OP_UNPIN;
        default: op = bftr_pkg::OP_DIRTY;
      endcase
      send_request(op, pg);
    end
    wait_drained();
  endtask

  task automatic test_random();
    hot_pages.delete();
    for (int i = 0; i < 24; i++) hot_pages.push_back(20'($urandom));
    hot_pages[0] = 20'hFFFFF;
    hot_pages[1] = 20'h00000;
    write_reg(bftr_pkg::REG_FRAMES, 32'd31);
    write_reg(bftr_pkg::REG_POLICY, 32'd0);
    random_phase(60, 24);
    write_reg(bftr_pkg::REG_POLICY, 32'd1);
    random_phase(60, 24);
    write_reg(bftr_pkg::REG_FRAMES, 32'd4);
    random_phase(55, 12);
    write_reg(bftr_pkg::REG_POLICY, 32'd0);
    write_reg(bftr_pkg::REG_FRAMES, 32'd16);
    random_phase(50, 20);
  endtask

  initial begin
    pool_clear();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_pool();
    test_random();
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire
